// ===== design/clts_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package clts_pkg;

  localparam int KEYWORD_CHARS   = 5;
  localparam int LENGTH_BITS     = 16;
  localparam int LINE_BITS       = 16;
  localparam int PREFIX_IDX_BITS = $clog2(KEYWORD_CHARS);

  localparam int QUEUE_DEPTH      = 4;
  localparam int QUEUE_IDX_BITS   = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_COUNT_BITS = $clog2(QUEUE_DEPTH + 1);

  typedef logic [4:0] kind_t;

  localparam kind_t KIND_EOF    = 5'd0;
  localparam kind_t KIND_AND    = 5'd1;
  localparam kind_t KIND_OR     = 5'd2;
  localparam kind_t KIND_EQ     = 5'd3;
  localparam kind_t KIND_NE     = 5'd4;
  localparam kind_t KIND_LE     = 5'd5;
  localparam kind_t KIND_GE     = 5'd6;
  localparam kind_t KIND_ID     = 5'd7;
  localparam kind_t KIND_NUM    = 5'd8;
  localparam kind_t KIND_TYPE   = 5'd9;
  localparam kind_t KIND_IF     = 5'd10;
  localparam kind_t KIND_ELSE   = 5'd11;
  localparam kind_t KIND_WHILE  = 5'd12;
  localparam kind_t KIND_BREAK  = 5'd13;
  localparam kind_t KIND_TRUE   = 5'd14;
  localparam kind_t KIND_FALSE  = 5'd15;
  localparam kind_t KIND_SINGLE = 5'd16;

  typedef struct packed {
    logic [7:0] source_byte;
    logic       end_of_input;
  } in_word_t;

  typedef struct packed {
    kind_t                  token_kind;
    logic [7:0]             token_char;
    logic [LENGTH_BITS-1:0] token_length;
    logic [LINE_BITS-1:0]   token_line;
    logic                   last_of_run;
  } out_word_t;

  // Tokens raised by one input word, oldest in tok_a.
  typedef struct packed {
    logic [1:0] count;
    out_word_t  tok_a;
    out_word_t  tok_b;
  } push_t;

endpackage

`default_nettype wire

// ===== design/clts_step.sv =====
`timescale 1ns / 1ps
`default_nettype none

module clts_step (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             fire,
  input  wire clts_pkg::in_word_t               word,
  input  wire logic                             cfg_write,
  input  wire logic [clts_pkg::LINE_BITS-1:0]   cfg_data,
  output clts_pkg::push_t                       push
);

  typedef enum logic [5:0] {
    MODE_IDLE     = 6'b000001,
    MODE_OP       = 6'b000010,
    MODE_NUM_INT  = 6'b000100,
    MODE_NUM_FRAC = 6'b001000,
    MODE_ID_ALPHA = 6'b010000,
    MODE_ID_DIGIT = 6'b100000
  } mode_t;

  typedef logic [0:clts_pkg::KEYWORD_CHARS-1][7:0] prefix_t;
  typedef logic [8*clts_pkg::KEYWORD_CHARS-1:0]    text_t;

  localparam logic [clts_pkg::LENGTH_BITS-1:0] LEN_MAX  = '1;
  localparam logic [clts_pkg::LINE_BITS-1:0]   LINE_MAX = '1;

  mode_t                            mode,       mode_next;
  prefix_t                          prefix,     prefix_next;
  logic [clts_pkg::LENGTH_BITS-1:0] plen,       plen_next;
  logic [7:0]                       first_byte, first_byte_next;
  logic [clts_pkg::LINE_BITS-1:0]   line,       line_next;
  logic                             ended,      ended_next;

  // Left-align the keyword so unused trailing bytes read as zero, as the prefix does.
  function automatic logic is_word(prefix_t p, logic [clts_pkg::LENGTH_BITS-1:0] n,
                                   text_t text, int len);
    text_t aligned;
    aligned = text << (8 * (clts_pkg::KEYWORD_CHARS - len));
    return (n == clts_pkg::LENGTH_BITS'(len)) && (p == aligned);
  endfunction

  function automatic clts_pkg::kind_t classify(prefix_t p,
                                               logic [clts_pkg::LENGTH_BITS-1:0] n);
    clts_pkg::kind_t k;
    k = clts_pkg::KIND_ID;
    if (is_word(p, n, text_t'("int"), 3) || is_word(p, n, text_t'("float"), 5) ||
        is_word(p, n, text_t'("bool"), 4))
      k = clts_pkg::KIND_TYPE;
    else if (is_word(p, n, text_t'("if"), 2))    k = clts_pkg::KIND_IF;
    else if (is_word(p, n, text_t'("else"), 4))  k = clts_pkg::KIND_ELSE;
    else if (is_word(p, n, text_t'("while"), 5)) k = clts_pkg::KIND_WHILE;
    else if (is_word(p, n, text_t'("break"), 5)) k = clts_pkg::KIND_BREAK;
    else if (is_word(p, n, text_t'("true"), 4))  k = clts_pkg::KIND_TRUE;
    else if (is_word(p, n, text_t'("false"), 5)) k = clts_pkg::KIND_FALSE;
    return k;
  endfunction

  function automatic clts_pkg::out_word_t make_tok(clts_pkg::kind_t k, logic [7:0] ch,
                                                   logic [clts_pkg::LENGTH_BITS-1:0] n,
                                                   logic [clts_pkg::LINE_BITS-1:0] ln);
    clts_pkg::out_word_t t;
    t.token_kind   = k;
    t.token_char   = ch;
    t.token_length = n;
    t.token_line   = ln;
    t.last_of_run  = 1'b0;
    return t;
  endfunction

  logic [7:0]          c;
  logic                is_digit, is_alpha, is_space, is_op;
  clts_pkg::kind_t     pair, flush_kind;
  clts_pkg::out_word_t flush_tok, eof_tok, single_tok;
  logic                ext_ok;

  always_comb begin
    c        = word.source_byte;
    is_digit = (c >= "0") && (c <= "9");
    is_alpha = ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z")) || (c == "_");
    is_space = (c == " ") || ((c >= 8'd9) && (c <= 8'd13));
    is_op    = (c == "&") || (c == "|") || (c == "=") || (c == "!") || (c == "<") ||
               (c == ">");

    pair = clts_pkg::KIND_EOF;
    if ((first_byte == "&") && (c == "&"))      pair = clts_pkg::KIND_AND;
    else if ((first_byte == "|") && (c == "|")) pair = clts_pkg::KIND_OR;
    else if (c == "=") begin
      if (first_byte == "=")      pair = clts_pkg::KIND_EQ;
      else if (first_byte == "!") pair = clts_pkg::KIND_NE;
      else if (first_byte == "<") pair = clts_pkg::KIND_LE;
      else if (first_byte == ">") pair = clts_pkg::KIND_GE;
    end

    case (mode)
      MODE_OP:       flush_kind = clts_pkg::KIND_SINGLE;
      MODE_NUM_INT,
      MODE_NUM_FRAC: flush_kind = clts_pkg::KIND_NUM;
      default:       flush_kind = classify(prefix, plen);
    endcase
    flush_tok  = make_tok(flush_kind, first_byte,
                          (mode == MODE_OP) ? clts_pkg::LENGTH_BITS'(1) : plen, line);
    eof_tok    = make_tok(clts_pkg::KIND_EOF, 8'd0, '0, line);
    single_tok = make_tok(clts_pkg::KIND_SINGLE, c, clts_pkg::LENGTH_BITS'(1), line);

    case (mode)
      MODE_OP:       ext_ok = (pair != clts_pkg::KIND_EOF);
      MODE_NUM_INT:  ext_ok = is_digit || (c == ".");
      MODE_NUM_FRAC,
      MODE_ID_DIGIT: ext_ok = is_digit;
      MODE_ID_ALPHA: ext_ok = is_alpha || is_digit;
      default:       ext_ok = 1'b0;
    endcase

    mode_next       = mode;
    prefix_next     = prefix;
    plen_next       = plen;
    first_byte_next = first_byte;
    line_next       = line;
    ended_next      = ended;
    push            = '0;

    if (ended) begin
      push.tok_a = eof_tok;
      push.count = 2'd1;
    end else if (word.end_of_input) begin
      if (mode != MODE_IDLE) begin
        push.tok_a = flush_tok;
        push.tok_b = eof_tok;
        push.count = 2'd2;
      end else begin
        push.tok_a = eof_tok;
        push.count = 2'd1;
      end
      mode_next  = MODE_IDLE;
      plen_next  = '0;
      ended_next = 1'b1;
    end else if (ext_ok) begin
      if (mode == MODE_OP) begin
        push.tok_a = make_tok(pair, first_byte, clts_pkg::LENGTH_BITS'(2), line);
        push.count = 2'd1;
        mode_next  = MODE_IDLE;
        plen_next  = '0;
      end else begin
        if (plen < clts_pkg::LENGTH_BITS'(clts_pkg::KEYWORD_CHARS))
          prefix_next[plen[clts_pkg::PREFIX_IDX_BITS-1:0]] = c;
        if (plen != LEN_MAX)
          plen_next = plen + 1'b1;
        if ((mode == MODE_NUM_INT) && (c == "."))
          mode_next = MODE_NUM_FRAC;
        else if ((mode == MODE_ID_ALPHA) && is_digit)
          mode_next = MODE_ID_DIGIT;
      end
    end else begin
      // Close the pending token, then scan this byte afresh.
      if (mode != MODE_IDLE) begin
        push.tok_a = flush_tok;
        push.count = 2'd1;
        mode_next  = MODE_IDLE;
        plen_next  = '0;
      end
      if (is_space) begin
        if ((c == 8'h0A) && (line != LINE_MAX))
          line_next = line + 1'b1;
      end else if (is_op || is_digit || is_alpha) begin
        prefix_next     = '0;
        prefix_next[0]  = c;
        plen_next       = clts_pkg::LENGTH_BITS'(1);
        first_byte_next = c;
        if (is_op)         mode_next = MODE_OP;
        else if (is_digit) mode_next = MODE_NUM_INT;
        else               mode_next = MODE_ID_ALPHA;
      end else if (push.count == 2'd0) begin
        push.tok_a = single_tok;
        push.count = 2'd1;
      end else begin
        push.tok_b = single_tok;
        push.count = 2'd2;
      end
    end

    if (push.count == 2'd1) push.tok_a.last_of_run = 1'b1;
    if (push.count == 2'd2) push.tok_b.last_of_run = 1'b1;
    if (!fire) push.count = 2'd0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= MODE_IDLE;
      prefix     <= '0;
      plen       <= '0;
      first_byte <= '0;
      line       <= '0;
      ended      <= 1'b0;
    end else begin
      if (fire) begin
        mode       <= mode_next;
        prefix     <= prefix_next;
        plen       <= plen_next;
        first_byte <= first_byte_next;
        ended      <= ended_next;
      end
      if (cfg_write)
        line <= cfg_data;
      else if (fire)
        line <= line_next;
    end
  end

endmodule

`default_nettype wire

// ===== design/clts_out_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none

module clts_out_queue (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire clts_pkg::push_t     push,
  input  wire logic                pop,
  output clts_pkg::out_word_t      head_word,
  output logic                     not_empty,
  output logic                     can_push
);

  typedef logic [clts_pkg::QUEUE_IDX_BITS-1:0]   idx_t;
  typedef logic [clts_pkg::QUEUE_COUNT_BITS-1:0] cnt_t;

  clts_pkg::out_word_t entries [clts_pkg::QUEUE_DEPTH];
  idx_t head, tail;
  cnt_t count;

  function automatic idx_t wrap_inc(idx_t i);
    return (i == idx_t'(clts_pkg::QUEUE_DEPTH - 1)) ? '0 : i + 1'b1;
  endfunction

  assign head_word = entries[head];
  assign not_empty = (count != '0);
  assign can_push  = (count <= cnt_t'(clts_pkg::QUEUE_DEPTH - 2));

  always_ff @(posedge clk) begin
    if (push.count != 2'd0)
      entries[tail] <= push.tok_a;
    if (push.count == 2'd2)
      entries[wrap_inc(tail)] <= push.tok_b;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      if (pop)
        head <= wrap_inc(head);
      if (push.count == 2'd1)
        tail <= wrap_inc(tail);
      else if (push.count == 2'd2)
        tail <= wrap_inc(wrap_inc(tail));
      count <= count + cnt_t'(push.count) - cnt_t'(pop);
    end
  end

endmodule

`default_nettype wire

// ===== design/c_like_token_scanner_core.sv =====
// Byte-serial scanner for a small C-like language. Each input word carries one
// source byte or an end-of-input mark; each output word is one token (kind,
// first byte, length, line, and a flag on the last token raised by that input
// word). The block takes one input word per clock unless in_stall is high: the
// word is registered, and the scan logic turns it combinationally into zero,
// one or two tokens that it pushes into a four-entry result queue, so a token
// passes the input register and then the queue on its way to the output. The
// output drains one token a clock while out_stall is low, so the output port
// sets the sustained rate: one word a cycle while no word raises two tokens.
// Write cfg_data with cfg_write only while the block is idle; it loads the line
// counter directly.
`timescale 1ns / 1ps
`default_nettype none

module c_like_token_scanner_core (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             in_valid,
  output logic                                  in_stall,
  input  wire clts_pkg::in_word_t               in_word,
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output clts_pkg::out_word_t                   out_word,
  input  wire logic                             cfg_write,
  input  wire logic [clts_pkg::LINE_BITS-1:0]   cfg_data
);

  // Input register: holds the accepted word until the queue has room for
  // the two tokens it may raise.
  logic               in_reg_valid;
  clts_pkg::in_word_t in_reg;

  logic            can_push;
  logic            fire;
  clts_pkg::push_t push;

  assign fire     = in_reg_valid && can_push;
  assign in_stall = in_reg_valid && !can_push;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_reg_valid <= 1'b0;
    end else if (!in_stall) begin
      in_reg_valid <= in_valid;
    end
  end

  // Payload only: load on accept, hold otherwise.
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall)
      in_reg <= in_word;
  end

  // Scan state and token formation; advances only when the word is taken, apart from a cfg_write to the line counter.
  clts_step u_step (
    .clk       (clk),
    .rst       (rst),
    .fire      (fire),
    .word      (in_reg),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data),
    .push      (push)
  );

  // Result queue decouples the scanner from a stalled consumer.
  clts_out_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .pop       (out_valid && !out_stall),
    .head_word (out_word),
    .not_empty (out_valid),
    .can_push  (can_push)
  );

  // A full queue must have something to drain, else the scanner deadlocks.
  a_full_has_output: assert property (@(posedge clk) disable iff (rst)
    !can_push |-> out_valid)
    else $error("queue refuses words while empty");

  // End of input always raises at least the end-of-file token.
  a_eoi_emits: assert property (@(posedge clk) disable iff (rst)
    (fire && in_reg.end_of_input) |-> (push.count != 2'd0))
    else $error("end of input raised no token");

  // Out of reset: nothing to deliver and free to accept.
  a_reset_clean: assert property (@(posedge clk)
    $past(rst) |-> (!out_valid && !in_stall))
    else $error("state not cleared by reset");

endmodule

`default_nettype wire
